// ===== rtl/icis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icis_pkg
// Types and constants shared by the inverse cubic interpolation step datapath.
// ----------------------------------------------------------------------------
package icis_pkg;

    localparam int QW         = 32;
    localparam int DW         = 33;
    localparam int DIV_STAGES = 32;
    // Input to output latency of one term unit, in cycles.
    localparam int TERM_LAT   = DIV_STAGES + 4;

    typedef logic signed [QW-1:0] t_q;
    typedef logic signed [DW-1:0] t_d;

    localparam t_q Q_MAX = t_q'(32'h7FFF_FFFF);
    localparam t_q Q_MIN = t_q'(32'h8000_0000);

    typedef struct packed {
        logic valid;
        logic den_zero;
        logic big;
        logic prod_zero;
        logic num_neg;
        logic quo_neg;
    } t_div_ctl;

endpackage

// ===== rtl/icis_term.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icis_term
// Pipelined term unit: (diff * f) / den, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module icis_term import icis_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_d   i_diff,
    input  t_q   i_f,
    input  t_d   i_den,
    output logic o_valid,
    output t_q   o_q,
    output logic o_zero,
    output logic o_ovf
);

    // Stage 0: magnitudes and signs.
    logic        r0_valid;
    logic [32:0] r0_mdiff;
    logic [31:0] r0_mf;
    logic [32:0] r0_mden;
    logic        r0_num_neg;
    logic        r0_den_neg;
    logic        r0_den_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= i_valid;
        end
        r0_mdiff    <= i_diff[32] ? 33'(-i_diff) : 33'(i_diff);
        r0_mf       <= i_f[31] ? 32'(-i_f) : 32'(i_f);
        r0_mden     <= i_den[32] ? 33'(-i_den) : 33'(i_den);
        r0_num_neg  <= i_diff[32] ^ i_f[31];
        r0_den_neg  <= i_den[32];
        r0_den_zero <= (i_den == '0);
    end

    // Stage 1: full width product.
    logic [64:0] w_prod;
    logic        r1_valid;
    logic [63:0] r1_prod;
    logic [32:0] r1_mden;
    logic        r1_num_neg;
    logic        r1_den_neg;
    logic        r1_den_zero;

    assign w_prod = 65'(r0_mdiff) * 65'(r0_mf);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= r0_valid;
        end
        r1_prod     <= w_prod[63:0];
        r1_mden     <= r0_mden;
        r1_num_neg  <= r0_num_neg;
        r1_den_neg  <= r0_den_neg;
        r1_den_zero <= r0_den_zero;
    end

    // Stage 2 and the divider chain. If the upper half of the product is not
    // below the divisor, the quotient needs more than 32 bits and saturates.
    logic [32:0] r_rem  [0:DIV_STAGES];
    logic [31:0] r_low  [0:DIV_STAGES];
    logic [31:0] r_quo  [0:DIV_STAGES];
    logic [32:0] r_mden [0:DIV_STAGES];
    t_div_ctl    r_ctl  [0:DIV_STAGES];
    t_div_ctl    n_ctl0;

    always_comb begin
        n_ctl0.valid     = r1_valid;
        n_ctl0.den_zero  = r1_den_zero;
        n_ctl0.big       = ({1'b0, r1_prod[63:32]} >= r1_mden);
        n_ctl0.prod_zero = (r1_prod == '0);
        n_ctl0.num_neg   = r1_num_neg;
        n_ctl0.quo_neg   = r1_num_neg ^ r1_den_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= n_ctl0;
        end
        r_rem[0]  <= {1'b0, r1_prod[63:32]};
        r_low[0]  <= r1_prod[31:0];
        r_quo[0]  <= '0;
        r_mden[0] <= r1_mden;
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [33:0] w_try;
        logic        w_ge;

        assign w_try = {r_rem[k], r_low[k][31]};
        assign w_ge  = (w_try >= {1'b0, r_mden[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1] <= '0;
            end else begin
                r_ctl[k+1] <= r_ctl[k];
            end
            r_rem[k+1]  <= w_ge ? 33'(w_try - {1'b0, r_mden[k]}) : w_try[32:0];
            r_low[k+1]  <= {r_low[k][30:0], 1'b0};
            r_quo[k+1]  <= {r_quo[k][30:0], w_ge};
            r_mden[k+1] <= r_mden[k];
        end
    end

    // Final stage: sign and saturation.
    t_div_ctl    w_ctl;
    logic [31:0] w_quo;
    t_q          n_q;
    logic        n_zero;
    logic        n_ovf;

    assign w_ctl = r_ctl[DIV_STAGES];
    assign w_quo = r_quo[DIV_STAGES];

    always_comb begin
        n_zero = 1'b0;
        n_ovf  = 1'b0;
        if (w_ctl.den_zero) begin
            n_zero = 1'b1;
            if (w_ctl.prod_zero) begin
                n_q = '0;
            end else begin
                n_q = w_ctl.num_neg ? Q_MIN : Q_MAX;
            end
        end else if (w_ctl.big) begin
            n_ovf = 1'b1;
            n_q   = w_ctl.quo_neg ? Q_MIN : Q_MAX;
        end else if (w_ctl.quo_neg) begin
            if (w_quo > 32'h8000_0000) begin
                n_ovf = 1'b1;
                n_q   = Q_MIN;
            end else begin
                n_q = t_q'(-w_quo);
            end
        end else begin
            if (w_quo[31]) begin
                n_ovf = 1'b1;
                n_q   = Q_MAX;
            end else begin
                n_q = t_q'(w_quo);
            end
        end
    end

    logic r_valid;
    t_q   r_q;
    logic r_zero;
    logic r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_ctl.valid;
        end
        r_q    <= n_q;
        r_zero <= n_zero;
        r_ovf  <= n_ovf;
    end

    assign o_valid = r_valid;
    assign o_q     = r_q;
    assign o_zero  = r_zero;
    assign o_ovf   = r_ovf;

endmodule

// ===== rtl/inverse_cubic_interpolation_step_top.sv =====
`timescale 1ns / 1ps
// The datapath is a pipeline with no stall; throughput is one beat per cycle,
// and busy is never raised.
// The latency is set by three dependent levels of term units, each a
// multiplier followed by a 32-stage restoring divider.
// Reset (synchronous, active low) clears all valid bits; the receiver cannot stall.
// ----------------------------------------------------------------------------
// inverse_cubic_interpolation_step_top
// Fixed point inverse cubic interpolation root estimate, fully pipelined.
// ----------------------------------------------------------------------------
module inverse_cubic_interpolation_step_top import icis_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_q   i_pt_a,
    input  t_q   i_pt_b,
    input  t_q   i_pt_d,
    input  t_q   i_pt_e,
    input  t_q   i_val_a,
    input  t_q   i_val_b,
    input  t_q   i_val_d,
    input  t_q   i_val_e,
    output logic o_valid,
    output t_q   o_root_estimate,
    output logic o_zero_divisor,
    output logic o_overflowed
);

    typedef struct packed {
        t_q a;
        t_q fa;
        t_q fb;
        t_q fd;
        t_q fe;
    } t_car1;

    typedef struct packed {
        t_q   a;
        t_q   fa;
        t_q   fe;
        t_q   q31;
        logic zero;
        logic ovf;
    } t_car2;

    typedef struct packed {
        t_q   a;
        t_q   q31;
        t_q   q32;
        logic zero;
        logic ovf;
    } t_car3;

    assign busy = 1'b0;

    // Input register.
    logic r_in_valid;
    t_q   r_a, r_b, r_d, r_e, r_fa, r_fb, r_fd, r_fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
        r_a  <= i_pt_a;
        r_b  <= i_pt_b;
        r_d  <= i_pt_d;
        r_e  <= i_pt_e;
        r_fa <= i_val_a;
        r_fb <= i_val_b;
        r_fd <= i_val_d;
        r_fe <= i_val_e;
    end

    // First level differences.
    logic  r1_valid;
    t_d    r1_de, r1_bd, r1_ab, r1_den_ed, r1_den_db, r1_den_ba;
    t_car1 r1_car;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= r_in_valid;
        end
        r1_de     <= t_d'(r_d) - t_d'(r_e);
        r1_bd     <= t_d'(r_b) - t_d'(r_d);
        r1_ab     <= t_d'(r_a) - t_d'(r_b);
        r1_den_ed <= t_d'(r_fe) - t_d'(r_fd);
        r1_den_db <= t_d'(r_fd) - t_d'(r_fb);
        r1_den_ba <= t_d'(r_fb) - t_d'(r_fa);
        r1_car    <= '{a: r_a, fa: r_fa, fb: r_fb, fd: r_fd, fe: r_fe};
    end

    logic v11, v21, v31, v_d21, v_d31;
    t_q   q11, q21, q31, d21, d31;
    logic z11, z21, z31, z_d21, z_d31;
    logic o11, o21, o31, o_d21, o_d31;

    icis_term u_q11 (.i_clk, .i_rst_n, .i_valid(r1_valid), .i_diff(r1_de),
        .i_f(r1_car.fd), .i_den(r1_den_ed), .o_valid(v11), .o_q(q11),
        .o_zero(z11), .o_ovf(o11));
    icis_term u_q21 (.i_clk, .i_rst_n, .i_valid(r1_valid), .i_diff(r1_bd),
        .i_f(r1_car.fb), .i_den(r1_den_db), .o_valid(v21), .o_q(q21),
        .o_zero(z21), .o_ovf(o21));
    icis_term u_q31 (.i_clk, .i_rst_n, .i_valid(r1_valid), .i_diff(r1_ab),
        .i_f(r1_car.fa), .i_den(r1_den_ba), .o_valid(v31), .o_q(q31),
        .o_zero(z31), .o_ovf(o31));
    icis_term u_d21 (.i_clk, .i_rst_n, .i_valid(r1_valid), .i_diff(r1_bd),
        .i_f(r1_car.fd), .i_den(r1_den_db), .o_valid(v_d21), .o_q(d21),
        .o_zero(z_d21), .o_ovf(o_d21));
    icis_term u_d31 (.i_clk, .i_rst_n, .i_valid(r1_valid), .i_diff(r1_ab),
        .i_f(r1_car.fb), .i_den(r1_den_ba), .o_valid(v_d31), .o_q(d31),
        .o_zero(z_d31), .o_ovf(o_d31));

    // Carried operands run alongside the term units so they meet the quotients.
    t_car1 r_dl1 [0:TERM_LAT-1];

    always_ff @(posedge i_clk) begin
        r_dl1[0] <= r1_car;
        for (int i = 1; i < TERM_LAT; i++) begin
            r_dl1[i] <= r_dl1[i-1];
        end
    end

    t_car1 w_c1;
    assign w_c1 = r_dl1[TERM_LAT-1];

    // Second level operands.
    logic  r2_valid;
    t_d    r2_x1, r2_x2, r2_den_eb, r2_den_da;
    t_q    r2_fb, r2_fd;
    t_car2 r2_car;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= v31;
        end
        r2_x1     <= t_d'(d21) - t_d'(q11);
        r2_x2     <= t_d'(d31) - t_d'(q21);
        r2_den_eb <= t_d'(w_c1.fe) - t_d'(w_c1.fb);
        r2_den_da <= t_d'(w_c1.fd) - t_d'(w_c1.fa);
        r2_fb     <= w_c1.fb;
        r2_fd     <= w_c1.fd;
        r2_car    <= '{a: w_c1.a, fa: w_c1.fa, fe: w_c1.fe, q31: q31,
                       zero: z11 | z21 | z31 | z_d21 | z_d31,
                       ovf:  o11 | o21 | o31 | o_d21 | o_d31};
    end

    logic v22, v32, v_d32;
    t_q   q22, q32, d32;
    logic z22, z32, z_d32;
    logic o22, o32, o_d32;

    icis_term u_q22 (.i_clk, .i_rst_n, .i_valid(r2_valid), .i_diff(r2_x1),
        .i_f(r2_fb), .i_den(r2_den_eb), .o_valid(v22), .o_q(q22),
        .o_zero(z22), .o_ovf(o22));
    icis_term u_q32 (.i_clk, .i_rst_n, .i_valid(r2_valid), .i_diff(r2_x2),
        .i_f(r2_car.fa), .i_den(r2_den_da), .o_valid(v32), .o_q(q32),
        .o_zero(z32), .o_ovf(o32));
    icis_term u_d32 (.i_clk, .i_rst_n, .i_valid(r2_valid), .i_diff(r2_x2),
        .i_f(r2_fd), .i_den(r2_den_da), .o_valid(v_d32), .o_q(d32),
        .o_zero(z_d32), .o_ovf(o_d32));

    t_car2 r_dl2 [0:TERM_LAT-1];

    always_ff @(posedge i_clk) begin
        r_dl2[0] <= r2_car;
        for (int i = 1; i < TERM_LAT; i++) begin
            r_dl2[i] <= r_dl2[i-1];
        end
    end

    t_car2 w_c2;
    assign w_c2 = r_dl2[TERM_LAT-1];

    // Third level operands.
    logic  r3_valid;
    t_d    r3_x, r3_den_ea;
    t_q    r3_fa;
    t_car3 r3_car;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= v22;
        end
        r3_x      <= t_d'(d32) - t_d'(q22);
        r3_den_ea <= t_d'(w_c2.fe) - t_d'(w_c2.fa);
        r3_fa     <= w_c2.fa;
        r3_car    <= '{a: w_c2.a, q31: w_c2.q31, q32: q32,
                       zero: w_c2.zero | z22 | z32 | z_d32,
                       ovf:  w_c2.ovf | o22 | o32 | o_d32};
    end

    logic v33, z33, o33;
    t_q   q33;

    icis_term u_q33 (.i_clk, .i_rst_n, .i_valid(r3_valid), .i_diff(r3_x),
        .i_f(r3_fa), .i_den(r3_den_ea), .o_valid(v33), .o_q(q33),
        .o_zero(z33), .o_ovf(o33));

    t_car3 r_dl3 [0:TERM_LAT-1];

    always_ff @(posedge i_clk) begin
        r_dl3[0] <= r3_car;
        for (int i = 1; i < TERM_LAT; i++) begin
            r_dl3[i] <= r_dl3[i-1];
        end
    end

    t_car3 w_c3;
    assign w_c3 = r_dl3[TERM_LAT-1];

    // Final sum with saturation.
    logic signed [33:0] w_sum;
    t_q                 n_root;
    logic               n_sat;

    assign w_sum = 34'(w_c3.q31) + 34'(w_c3.q32) + 34'(q33) + 34'(w_c3.a);

    always_comb begin
        n_sat = 1'b0;
        if (w_sum > 34'(Q_MAX)) begin
            n_sat  = 1'b1;
            n_root = Q_MAX;
        end else if (w_sum < 34'(Q_MIN)) begin
            n_sat  = 1'b1;
            n_root = Q_MIN;
        end else begin
            n_root = w_sum[31:0];
        end
    end

    logic r_out_valid;
    t_q   r_root;
    logic r_zero;
    logic r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= v33;
        end
        r_root <= n_root;
        r_zero <= w_c3.zero | z33;
        r_ovf  <= w_c3.ovf | o33 | n_sat;
    end

    assign o_valid         = r_out_valid;
    assign o_root_estimate = r_root;
    assign o_zero_divisor  = r_zero;
    assign o_overflowed    = r_ovf;

endmodule

// ===== tb/icis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icis_checker
// Watches the command and result ports of the inverse cubic interpolation
// step, predicts each result from the accepted beat, and compares in order.
// ----------------------------------------------------------------------------
module icis_checker import icis_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_q   i_pt_a,
    input  t_q   i_pt_b,
    input  t_q   i_pt_d,
    input  t_q   i_pt_e,
    input  t_q   i_val_a,
    input  t_q   i_val_b,
    input  t_q   i_val_d,
    input  t_q   i_val_e,
    input  logic i_valid,
    input  t_q   i_root_estimate,
    input  logic i_zero_divisor,
    input  logic i_overflowed,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        t_q   root;
        logic zdiv;
        logic ovf;
    } t_root_res;

    t_root_res root_fifo[$];
    logic      zero_seen;
    logic      ovf_seen;

    assign o_pending = root_fifo.size();

    initial o_errors = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_errors++;
    endtask

    // One term: (diff * f) / den, truncated toward zero, saturated to 32 bits.
    function automatic longint calc_term(input longint diff, input longint f,
                                         input longint den);
        logic [63:0] prod;
        logic [63:0] quo;
        logic        neg;
        prod = (diff < 0 ? -diff : diff) * (f < 0 ? -f : f);
        neg  = (diff < 0) != (f < 0);
        if (den == 0) begin
            zero_seen = 1'b1;
            if (prod == 0) return 0;
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        end
        quo = prod / (den < 0 ? -den : den);
        if (neg != (den < 0)) begin
            if (quo > 64'h8000_0000) begin
                ovf_seen = 1'b1;
                return -64'sd2147483648;
            end
            return -longint'(quo);
        end
        if (quo > 64'h7FFF_FFFF) begin
            ovf_seen = 1'b1;
            return 64'sd2147483647;
        end
        return longint'(quo);
    endfunction

    function automatic t_root_res predict_root(input t_q pa, pb, pd, pe,
                                               input t_q fa_q, fb_q, fd_q, fe_q);
        longint a, b, d, e, fa, fb, fd, fe;
        longint q11, q21, q31, d21, d31, q22, q32, d32, q33, sum;
        t_root_res r;
        a = pa; b = pb; d = pd; e = pe;
        fa = fa_q; fb = fb_q; fd = fd_q; fe = fe_q;
        zero_seen = 1'b0;
        ovf_seen  = 1'b0;
        q11 = calc_term(d - e, fd, fe - fd);
        q21 = calc_term(b - d, fb, fd - fb);
        q31 = calc_term(a - b, fa, fb - fa);
        d21 = calc_term(b - d, fd, fd - fb);
        d31 = calc_term(a - b, fb, fb - fa);
        q22 = calc_term(d21 - q11, fb, fe - fb);
        q32 = calc_term(d31 - q21, fa, fd - fa);
        d32 = calc_term(d31 - q21, fd, fd - fa);
        q33 = calc_term(d32 - q22, fa, fe - fa);
        sum = q31 + q32 + q33 + a;
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            ovf_seen = 1'b1;
        end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            ovf_seen = 1'b1;
        end
        r.root = t_q'(sum);
        r.zdiv = zero_seen;
        r.ovf  = ovf_seen;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_root_res want;
        if (i_rst_n) begin
            if (i_start && !i_busy)
                root_fifo.push_back(predict_root(i_pt_a, i_pt_b, i_pt_d, i_pt_e,
                                                 i_val_a, i_val_b, i_val_d, i_val_e));
            if (i_valid) begin
                if (root_fifo.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = root_fifo.pop_front();
                    if (i_root_estimate !== want.root)
                        report_mismatch($sformatf("root_estimate got %h want %h",
                                                  i_root_estimate, want.root));
                    if (i_zero_divisor !== want.zdiv)
                        report_mismatch($sformatf("zero_divisor got %b want %b",
                                                  i_zero_divisor, want.zdiv));
                    if (i_overflowed !== want.ovf)
                        report_mismatch($sformatf("overflowed got %b want %b",
                                                  i_overflowed, want.ovf));
                end
            end
        end
    end

endmodule

// ===== tb/tb_inverse_cubic_interpolation_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inverse_cubic_interpolation_step_top
// Drives directed corner beats, then bursts of random beats with random gaps,
// into the root estimator; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_inverse_cubic_interpolation_step_top;
    import icis_pkg::*;

    localparam int N_RANDOM   = 880;
    localparam int DRAIN_CYC  = 150;
    localparam int STUCK_MAX  = 2000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_q   pt_a, pt_b, pt_d, pt_e, val_a, val_b, val_d, val_e;
    logic o_valid;
    t_q   o_root_estimate;
    logic o_zero_divisor;
    logic o_overflowed;
    int   err_count;
    int   pending;
    int   idle_cycles = 0;

    inverse_cubic_interpolation_step_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pt_a(pt_a), .i_pt_b(pt_b), .i_pt_d(pt_d), .i_pt_e(pt_e),
        .i_val_a(val_a), .i_val_b(val_b), .i_val_d(val_d), .i_val_e(val_e),
        .o_valid(o_valid), .o_root_estimate(o_root_estimate),
        .o_zero_divisor(o_zero_divisor), .o_overflowed(o_overflowed)
    );

    icis_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_pt_a(pt_a), .i_pt_b(pt_b), .i_pt_d(pt_d), .i_pt_e(pt_e),
        .i_val_a(val_a), .i_val_b(val_b), .i_val_d(val_d), .i_val_e(val_e),
        .i_valid(o_valid), .i_root_estimate(o_root_estimate),
        .i_zero_divisor(o_zero_divisor), .i_overflowed(o_overflowed),
        .o_errors(err_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: too many cycles in a row with no beat in either direction.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STUCK_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly small values near each other, plus full range and corner values.
    function automatic t_q rand_q(input int mode);
        case (mode)
            0: return t_q'($urandom);
            1: return t_q'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
            2: return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
            default: return t_q'($urandom_range(0, 3)) - t_q'(1);
        endcase
    endfunction

    // Present one beat and hold it until accepted.
    task automatic send_beat(input t_q a, b, d, e, fa, fb, fd, fe);
        start <= 1'b1;
        pt_a <= a; pt_b <= b; pt_d <= d; pt_e <= e;
        val_a <= fa; val_b <= fb; val_d <= fd; val_e <= fe;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_random;
        int m;
        t_q a, b, d, e;
        m = $urandom_range(0, 9);
        a = rand_q(m < 6 ? 1 : (m < 8 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 3)));
        b = rand_q(m < 6 ? 1 : 0);
        d = rand_q(m < 6 ? 1 : 0);
        e = (m == 9) ? d : rand_q(m < 6 ? 1 : 0);
        send_beat(a, b, d, e, rand_q(m < 5 ? 1 : $urandom_range(0, 3)),
                  rand_q(m < 5 ? 1 : $urandom_range(0, 3)),
                  rand_q(m < 5 ? 1 : $urandom_range(0, 3)),
                  rand_q(m < 5 ? 1 : $urandom_range(0, 3)));
    endtask

    initial begin
        int burst;
        int gap;
        int sent;
        int drain;
        i_rst_n = 1'b0;
        start = 1'b0;
        pt_a = '0; pt_b = '0; pt_d = '0; pt_e = '0;
        val_a = '0; val_b = '0; val_d = '0; val_e = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats: ordinary root, all zero, equal values (zero divisors),
        // extremes of every field, and quotients that overflow.
        send_beat(32'sh0000_0000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                  -32'sh0001_0000, 32'sh0000_8000, 32'sh0002_0000, 32'sh0004_0000);
        send_beat('0, '0, '0, '0, '0, '0, '0, '0);
        send_beat(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                  32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        send_beat(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        send_beat(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        send_beat(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_beat(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_beat(Q_MAX, Q_MIN, 32'sd1, -32'sd1, 32'sd1, 32'sd2, 32'sd3, 32'sd4);
        send_beat(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 32'sd0, 32'sd1, -32'sd1);
        send_beat(Q_MIN, Q_MAX, 32'sd0, Q_MAX, Q_MAX, Q_MAX - 1, Q_MIN, Q_MIN + 1);
        send_beat(32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd1, 32'sd2, 32'sd3, 32'sd4);
        send_beat(Q_MAX, 32'sd0, Q_MIN, 32'sd0, -32'sd1, 32'sd0, Q_MAX, 32'sd1);

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
            for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
                send_random();
                sent++;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        drain = 0;
        while (pending != 0 && drain < 10000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
